@@ src/triplet_delta_rice_encoder_assert.svh @@
// Assertion macros for the encoder's checker file.
`ifndef TRIPLET_DELTA_RICE_ENCODER_ASSERT_SVH
`define TRIPLET_DELTA_RICE_ENCODER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define TDRE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdre assertion failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define TDRE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdre assertion failed");

`endif

@@ src/tdre_pkg.sv @@
// Package: constants and types shared by the triplet delta Rice encoder.
package tdre_pkg;

	localparam int AXIS_COUNT = 3;
	localparam int AXIS_W     = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

	localparam int CHUNK_BITS = 32;
	localparam int CHUNK_EFF  = (CHUNK_BITS > 32) ? 32 : CHUNK_BITS;
	localparam int CNT_W      = $clog2(CHUNK_EFF + 1);

	localparam int SAMPLE_W = 8;
	localparam int K_W      = 3;
	localparam int U_W      = SAMPLE_W + 1;  // zigzag value, up to 510
	localparam int TAIL_W   = 8;             // zero bit plus up to seven remainder bits
	localparam int TOTAL_W  = U_W + 1;       // codeword length, up to 511

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	// One classified sample, handed from the front to the back.
	typedef struct packed {
		logic [TAIL_W-1:0]  tail;   // zero separator in bit 0, remainder above it
		logic [U_W-1:0]     ones;   // unary length q
		logic [TOTAL_W-1:0] total;  // codeword length q + 1 + k
	} entry_t;

endpackage

@@ src/tdre_if.sv @@
// Interfaces: sample input channel and code chunk output channel.
interface tdre_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [tdre_pkg::SAMPLE_W-1:0]   sample;
	logic                                   start_message;

	modport source (output valid, output sample, output start_message, input ready);
	modport sink (input valid, input sample, input start_message, output ready);
endinterface

interface tdre_chunk_if;
	logic                           valid;
	logic                           ready;
	logic [tdre_pkg::CHUNK_EFF-1:0] code_bits;
	logic [tdre_pkg::CNT_W-1:0]     bit_count;
	logic                           last_chunk;

	modport source (output valid, output code_bits, output bit_count, output last_chunk,
		input ready);
	modport sink (input valid, input code_bits, input bit_count, input last_chunk,
		output ready);
endinterface

@@ src/tdre_front.sv @@
// Front end: axis delta, zigzag map and Rice split of each sample.
module tdre_front (
	input  logic                          clk,
	input  logic                          arst_n,
	tdre_sample_if.sink                   samples,
	input  logic [tdre_pkg::K_W-1:0]      rice_k,
	output logic                          push,
	output tdre_pkg::entry_t              push_data,
	input  logic                          full
);

	logic signed [tdre_pkg::SAMPLE_W-1:0] base_q [tdre_pkg::AXIS_COUNT];
	logic [tdre_pkg::AXIS_W-1:0]          pos_q;

	logic [tdre_pkg::AXIS_W-1:0]          pos_cur;
	logic [tdre_pkg::AXIS_W-1:0]          pos_nxt;
	logic signed [tdre_pkg::SAMPLE_W-1:0] base;
	logic [tdre_pkg::U_W-1:0]             diff;
	logic [tdre_pkg::U_W:0]               two_d;
	logic [tdre_pkg::U_W-1:0]             u;
	logic [tdre_pkg::TAIL_W-1:0]          k_mask;
	logic [tdre_pkg::U_W-1:0]             q;

	assign samples.ready = !full;
	assign push          = samples.valid && !full;

	always_comb begin
		pos_cur = samples.start_message ? '0 : pos_q;
		pos_nxt = (pos_cur == tdre_pkg::AXIS_W'(tdre_pkg::AXIS_COUNT - 1)) ? '0
			: pos_cur + tdre_pkg::AXIS_W'(1);
		base    = samples.start_message ? '0 : base_q[pos_cur];
		diff    = {samples.sample[tdre_pkg::SAMPLE_W-1], samples.sample}
			- {base[tdre_pkg::SAMPLE_W-1], base};
		// zigzag: 2d for d >= 0, -2d-1 = ~(2d) otherwise
		two_d   = {diff, 1'b0};
		u       = diff[tdre_pkg::U_W-1] ? ~two_d[tdre_pkg::U_W-1:0] : two_d[tdre_pkg::U_W-1:0];
		k_mask  = (tdre_pkg::TAIL_W'(1) << rice_k) - tdre_pkg::TAIL_W'(1);
		q       = u >> rice_k;
		push_data.tail  = {u[tdre_pkg::TAIL_W-2:0] & k_mask[tdre_pkg::TAIL_W-2:0], 1'b0};
		push_data.ones  = q;
		push_data.total = {1'b0, q} + tdre_pkg::TOTAL_W'(1) + tdre_pkg::TOTAL_W'(rice_k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < tdre_pkg::AXIS_COUNT; i++) base_q[i] <= '0;
		end else if (push) begin
			for (int i = 0; i < tdre_pkg::AXIS_COUNT; i++) begin
				if (samples.start_message) base_q[i] <= '0;
			end
			base_q[pos_cur] <= samples.sample;
			pos_q           <= pos_nxt;
		end
	end

endmodule

@@ src/tdre_fifo.sv @@
// Short queue of classified samples between front and back.
module tdre_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tdre_pkg::entry_t push_data,
	output logic             full,
	input  logic             pop,
	output tdre_pkg::entry_t pop_data,
	output logic             empty
);

	tdre_pkg::entry_t                mem [tdre_pkg::FIFO_DEPTH];
	logic [tdre_pkg::FIFO_AW-1:0]    wr_q;
	logic [tdre_pkg::FIFO_AW-1:0]    rd_q;
	logic [tdre_pkg::FIFO_AW:0]      cnt_q;

	assign full     = (cnt_q == (tdre_pkg::FIFO_AW+1)'(tdre_pkg::FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem[rd_q];

	function automatic logic [tdre_pkg::FIFO_AW-1:0] ptr_inc(
		input logic [tdre_pkg::FIFO_AW-1:0] p);
		ptr_inc = (p == tdre_pkg::FIFO_AW'(tdre_pkg::FIFO_DEPTH - 1)) ? '0
			: p + tdre_pkg::FIFO_AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push && !full) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= ptr_inc(wr_q);
			if (pop && !empty) rd_q <= ptr_inc(rd_q);
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + (tdre_pkg::FIFO_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (tdre_pkg::FIFO_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ src/tdre_back.sv @@
// Back end: cuts each codeword into output chunks.
module tdre_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tdre_pkg::entry_t pop_data,
	input  logic             empty,
	output logic             pop,
	tdre_chunk_if.source     chunks
);

	logic                             busy_q;
	tdre_pkg::entry_t                 cur_q;
	logic [tdre_pkg::TOTAL_W-1:0]     pos_q;
	logic                             ov_q;
	logic [tdre_pkg::CHUNK_EFF-1:0]   bits_q;
	logic [tdre_pkg::CNT_W-1:0]       cnt_q;
	logic                             last_q;

	logic                             step;
	logic [tdre_pkg::TOTAL_W-1:0]     rem;
	logic                             last;
	logic [tdre_pkg::CNT_W-1:0]       cnt;
	logic [tdre_pkg::TOTAL_W-1:0]     ones_ext;
	logic [tdre_pkg::TOTAL_W-1:0]     off;
	logic                             ahead;
	logic [tdre_pkg::CHUNK_EFF:0]     ones_mask;
	logic [tdre_pkg::CHUNK_EFF+tdre_pkg::TAIL_W-1:0] tail_wide;
	logic [tdre_pkg::CHUNK_EFF-1:0]   tail_bits;
	logic [tdre_pkg::CHUNK_EFF-1:0]   bits;

	assign pop  = !busy_q && !empty;
	assign step = busy_q && (!ov_q || chunks.ready);

	always_comb begin
		rem      = cur_q.total - pos_q;
		last     = (rem <= tdre_pkg::TOTAL_W'(tdre_pkg::CHUNK_EFF));
		cnt      = last ? rem[tdre_pkg::CNT_W-1:0] : tdre_pkg::CNT_W'(tdre_pkg::CHUNK_EFF);
		ones_ext = {1'b0, cur_q.ones};
		ahead    = (ones_ext >= pos_q);
		off      = ahead ? (ones_ext - pos_q) : (pos_q - ones_ext);
		// unary ones that fall in this chunk
		ones_mask = '0;
		if (ahead) begin
			if (off >= tdre_pkg::TOTAL_W'(tdre_pkg::CHUNK_EFF)) ones_mask = '1;
			else ones_mask = ((tdre_pkg::CHUNK_EFF+1)'(1) << off[tdre_pkg::CNT_W-1:0])
				- (tdre_pkg::CHUNK_EFF+1)'(1);
		end
		// separator and remainder bits, placed where the unary run ends
		tail_wide = '0;
		tail_bits = '0;
		if (ahead) begin
			if (off < tdre_pkg::TOTAL_W'(tdre_pkg::CHUNK_EFF)) begin
				tail_wide = (tdre_pkg::CHUNK_EFF+tdre_pkg::TAIL_W)'(cur_q.tail)
					<< off[tdre_pkg::CNT_W-1:0];
				tail_bits = tail_wide[tdre_pkg::CHUNK_EFF-1:0];
			end
		end else begin
			tail_bits = tdre_pkg::CHUNK_EFF'(cur_q.tail >> off[3:0]);
		end
		bits = ones_mask[tdre_pkg::CHUNK_EFF-1:0] | tail_bits;
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= pop_data;
		if (step) begin
			bits_q <= bits;
			cnt_q  <= cnt;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (step) begin
				pos_q <= pos_q + tdre_pkg::TOTAL_W'(tdre_pkg::CHUNK_EFF);
				if (last) busy_q <= 1'b0;
			end
			if (step) ov_q <= 1'b1;
			else if (chunks.ready) ov_q <= 1'b0;
		end
	end

	assign chunks.valid      = ov_q;
	assign chunks.code_bits  = bits_q;
	assign chunks.bit_count  = cnt_q;
	assign chunks.last_chunk = last_q;

endmodule

@@ src/triplet_delta_rice_encoder.sv @@
// Top level: triplet delta Rice encoder, front, queue and back.
//
//   channel   dir   handshake                  word
//   samples   in    samples.valid/ready        sample, start_message
//   chunks    out   chunks.valid/ready         code_bits, bit_count, last_chunk
//   cfg       in    cfg_we (no wait)           cfg_wdata -> rice_k
//
// The front classifies a sample in the cycle it is accepted and writes it straight
// into a two-entry queue. The back pulls a sample into its codeword register, then
// puts out one 32-bit chunk per cycle while chunks.ready allows: ceil((q+1+k)/32)
// chunks, so 1 to 16 per sample. Reset clears the axis baselines, axis position,
// rice_k and all valid flags. A stalled chunk holds in the output register while the
// front keeps accepting samples until the queue is full.
module triplet_delta_rice_encoder (
	input  logic                     clk,
	input  logic                     arst_n,
	tdre_sample_if.sink              samples,
	tdre_chunk_if.source             chunks,
	input  logic                     cfg_we,
	input  logic [tdre_pkg::K_W-1:0] cfg_wdata
);

	logic [tdre_pkg::K_W-1:0] rice_k_q;
	logic                     push;
	tdre_pkg::entry_t         push_data;
	logic                     full;
	logic                     pop;
	tdre_pkg::entry_t         pop_data;
	logic                     empty;

	// Hold rice_k; write it only while the block is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rice_k_q <= '0;
		else if (cfg_we) rice_k_q <= cfg_wdata;
	end

	// Classify each sample into unary length, tail and codeword length.
	tdre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.rice_k    (rice_k_q),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Decouple the front from a stalled output.
	tdre_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// Cut the codeword into chunks and drive the output word.
	tdre_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.empty    (empty),
		.pop      (pop),
		.chunks   (chunks)
	);

endmodule

@@ src/tdre_checker.sv @@
// Port-level checker for the encoder, bound to the top level.
`include "triplet_delta_rice_encoder_assert.svh"

module tdre_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [tdre_pkg::CHUNK_EFF-1:0]      code_bits,
	input logic [tdre_pkg::CNT_W-1:0]          bit_count,
	input logic                                last_chunk
);

	`TDRE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(code_bits) && $stable(bit_count) && $stable(last_chunk))
	`TDRE_ASSERT_IMPL(a_full, out_valid && !last_chunk, bit_count == tdre_pkg::CNT_W'(tdre_pkg::CHUNK_EFF))
	`TDRE_ASSERT_IMPL(a_clean, out_valid, bit_count != '0 && bit_count <= tdre_pkg::CNT_W'(tdre_pkg::CHUNK_EFF) && (code_bits >> bit_count) == '0)
	`TDRE_ASSERT_NEXT(a_burst, out_valid && out_ready && !last_chunk, out_valid)

endmodule

bind triplet_delta_rice_encoder tdre_checker u_tdre_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (chunks.valid),
	.out_ready  (chunks.ready),
	.code_bits  (chunks.code_bits),
	.bit_count  (chunks.bit_count),
	.last_chunk (chunks.last_chunk)
);

@@ test/tb_triplet_delta_rice_encoder.sv @@
// Self-checking testbench for the triplet delta Rice encoder: directed and random samples.
module tb_triplet_delta_rice_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	// Give up after this many cycles in which neither channel moves a word.
	localparam int IDLE_LIMIT   = 2000;
	// Length of the long receiver hold-off that fills the block up.
	localparam int LONG_HOLD    = 300;
	// Cycles to let pass once nothing is expected any more.
	localparam int SETTLE       = 20;
	localparam int SEGMENT_ITEMS = 58;

	// One expected or observed output word.
	typedef struct packed {
		logic [tdre_pkg::CHUNK_EFF-1:0] code_bits;
		logic [tdre_pkg::CNT_W-1:0]     bit_count;
		logic                           last_chunk;
	} chunk_t;

	// Predicts the chunk stream of every accepted sample and checks the words
	// leaving the block against it, oldest first.
	class chunk_scoreboard;
		logic signed [tdre_pkg::SAMPLE_W-1:0] axis_prev [tdre_pkg::AXIS_COUNT];
		int unsigned                          axis_at;
		logic [tdre_pkg::K_W-1:0]             rice_k;
		chunk_t                               expected_chunks [$];
		int                                   errors;

		function new();
			foreach (axis_prev[i])
				axis_prev[i] = '0;
			axis_at = 0;
			rice_k  = '0;
			errors  = 0;
		endfunction

		function void set_rice_k(logic [tdre_pkg::K_W-1:0] k);
			rice_k = k;
		endfunction

		function int pending();
			return expected_chunks.size();
		endfunction

		// Bit idx of the codeword: q ones, a zero, then remainder bits LSB first.
		function logic code_bit(int unsigned idx, int unsigned q, int unsigned u);
			if (idx < q)
				return 1'b1;
			if (idx == q)
				return 1'b0;
			return logic'((u >> (idx - q - 1)) & 1);
		endfunction

		function void note_sample(logic signed [tdre_pkg::SAMPLE_W-1:0] s, logic start);
			int          d;
			int unsigned u;
			int unsigned q;
			int unsigned total;
			int unsigned pos;
			int unsigned cnt;
			chunk_t      c;
			if (start) begin
				foreach (axis_prev[i])
					axis_prev[i] = '0;
				axis_at = 0;
			end
			d = int'(s) - int'(axis_prev[axis_at]);
			axis_prev[axis_at] = s;
			axis_at = (axis_at + 1) % tdre_pkg::AXIS_COUNT;
			u = (d >= 0) ? 2 * d : -2 * d - 1;
			q = u >> rice_k;
			total = q + 1 + rice_k;
			pos = 0;
			while (pos < total) begin
				c = '0;
				cnt = 0;
				while (cnt < tdre_pkg::CHUNK_EFF && pos < total) begin
					c.code_bits[cnt] = code_bit(pos, q, u);
					cnt++;
					pos++;
				end
				c.bit_count  = tdre_pkg::CNT_W'(cnt);
				c.last_chunk = (pos == total);
				expected_chunks.push_back(c);
			end
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_chunk(chunk_t got);
			chunk_t want;
			if (expected_chunks.size() == 0) begin
				report($sformatf("unexpected chunk bits=%h count=%0d last=%0d",
					got.code_bits, got.bit_count, got.last_chunk));
				return;
			end
			want = expected_chunks.pop_front();
			if (got.code_bits !== want.code_bits)
				report($sformatf("code_bits got %h want %h", got.code_bits, want.code_bits));
			if (got.bit_count !== want.bit_count)
				report($sformatf("bit_count got %0d want %0d", got.bit_count, want.bit_count));
			if (got.last_chunk !== want.last_chunk)
				report($sformatf("last_chunk got %0d want %0d",
					got.last_chunk, want.last_chunk));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [tdre_pkg::K_W-1:0] cfg_wdata;

	tdre_sample_if samples_if ();
	tdre_chunk_if  chunks_if ();

	triplet_delta_rice_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.chunks    (chunks_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	chunk_scoreboard sb = new();

	// Idle odds in percent per cycle, set by the phase in progress.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// Nonzero asks the receiver to hold off for that many cycles.
	int hold_len = 0;
	int idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: drop ready at random, or hold it low for a long stretch on request.
	initial begin
		int stall;
		chunks_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				chunks_if.ready <= 1'b0;
			end else if (hold_len != 0) begin
				stall = hold_len;
				hold_len <= 0;
				chunks_if.ready <= 1'b0;
				// Count the stall here; the sender keeps offering meanwhile.
				repeat (stall - 1) @(posedge clk);
			end else begin
				chunks_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Check every output word at the edge that accepts it.
	always @(posedge clk) begin
		chunk_t got;
		if (arst_n && chunks_if.valid && chunks_if.ready) begin
			got.code_bits  = chunks_if.code_bits;
			got.bit_count  = chunks_if.bit_count;
			got.last_chunk = chunks_if.last_chunk;
			sb.check_chunk(got);
		end
	end

	// Watchdog: end the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples_if.valid && samples_if.ready) || (chunks_if.valid && chunks_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL triplet_delta_rice_encoder");
				$finish;
			end
		end
	end

	// Offer one sample word, after a random gap, and hold it until accepted.
	task automatic send_sample(logic signed [tdre_pkg::SAMPLE_W-1:0] s, logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid         <= 1'b1;
		samples_if.sample        <= s;
		samples_if.start_message <= start;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		sb.note_sample(s, start);
	endtask

	// Lower valid and advance until every expected word has come out.
	task automatic wait_drained();
		samples_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		// The back may still be busy with the last sample's final cycle.
		repeat (4) @(posedge clk);
	endtask

	// Write rice_k while the block is idle.
	task automatic write_rice_k(logic [tdre_pkg::K_W-1:0] k);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_rice_k(k);
		@(posedge clk);
	endtask

	// Random samples, mostly well-formed messages of whole triplets with
	// small deltas, plus full-range values, extremes and stray message starts.
	task automatic send_random(int n);
		logic signed [tdre_pkg::SAMPLE_W-1:0] prev [tdre_pkg::AXIS_COUNT];
		logic signed [tdre_pkg::SAMPLE_W-1:0] s;
		int                                   ax;
		int                                   msg_left;
		int                                   pick;
		logic                                 start;
		ax = 0;
		msg_left = 0;
		foreach (prev[i])
			prev[i] = '0;
		for (int i = 0; i < n; i++) begin
			start = 1'b0;
			if (msg_left == 0) begin
				start = 1'b1;
				msg_left = tdre_pkg::AXIS_COUNT * $urandom_range(8, 1);
			end else if ($urandom_range(99) < 5) begin
				// Break the message: restart it early, possibly mid-triplet.
				start = 1'b1;
				msg_left = tdre_pkg::AXIS_COUNT * $urandom_range(6, 1);
			end
			if (start) begin
				foreach (prev[j])
					prev[j] = '0;
				ax = 0;
			end
			pick = $urandom_range(9);
			if (pick < 5)
				s = prev[ax] + tdre_pkg::SAMPLE_W'($urandom_range(16) - 8);
			else if (pick < 8)
				s = tdre_pkg::SAMPLE_W'($urandom_range(255));
			else if (pick == 8)
				s = $urandom_range(1) ? 8'sd127 : -8'sd128;
			else
				s = '0;
			send_sample(s, start);
			prev[ax] = s;
			ax = (ax + 1) % tdre_pkg::AXIS_COUNT;
			msg_left--;
		end
	endtask

	initial begin
		logic [tdre_pkg::K_W-1:0] seg_k [6];
		seg_k = '{3'd3, 3'd0, 3'd7, 3'd1, 3'd5, 3'd2};

		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_wdata                = '0;
		samples_if.valid         = 1'b0;
		samples_if.sample        = '0;
		samples_if.start_message = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at k = 0: extremes, longest codewords, mid-triplet starts.
		write_rice_k(3'd0);
		send_sample(8'sd0, 1'b1);
		send_sample(8'sd127, 1'b0);
		send_sample(-8'sd128, 1'b0);
		send_sample(-8'sd128, 1'b0);
		send_sample(8'sd127, 1'b0);
		// d = +255 on the third axis: the 511-bit, sixteen-chunk codeword.
		send_sample(8'sd127, 1'b0);
		send_sample(8'sd127, 1'b0);
		send_sample(-8'sd128, 1'b0);
		// Restart the message with the position on the third axis.
		send_sample(-8'sd1, 1'b1);
		send_sample(8'sd1, 1'b0);
		// Restart it again on the third axis.
		send_sample(8'sd64, 1'b1);
		send_sample(8'sd0, 1'b0);

		// Same at the top Rice parameter.
		write_rice_k(3'd7);
		send_sample(8'sd127, 1'b1);
		send_sample(-8'sd128, 1'b0);
		send_sample(8'sd0, 1'b0);
		send_sample(-8'sd128, 1'b0);
		send_sample(8'sd127, 1'b0);
		send_sample(-8'sd1, 1'b0);
		send_sample(8'sd1, 1'b0);
		send_sample(-8'sd128, 1'b1);

		// Random part: two segments per idling phase, a new k for each segment.
		for (int seg = 0; seg < 6; seg++) begin
			write_rice_k(seg_k[seg]);
			if (seg < 2) begin
				send_idle_pct = 27;
				recv_idle_pct = 53;
			end else if (seg < 4) begin
				send_idle_pct = 53;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// Stall the output long enough for the queue to fill and block input.
			if (seg == 1)
				hold_len <= LONG_HOLD;
			if (seg == 4) begin
				send_random(SEGMENT_ITEMS / 2);
				// Pause the sender until the block has emptied out.
				wait_drained();
				send_random(SEGMENT_ITEMS - SEGMENT_ITEMS / 2);
			end else begin
				send_random(SEGMENT_ITEMS);
			end
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS triplet_delta_rice_encoder");
		else
			$display("FAIL triplet_delta_rice_encoder");
		$finish;
	end

endmodule
